@@ hw/rtl/ssl_pkg.sv @@
// shared types, constants and register indexes for the servo slew limiter
package ssl_pkg;

    localparam int ANGLE_W = 8;
    localparam int PULSE_W = 12;
    localparam int TARGET_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam int PULSE_MAX = 4095;

    // divide by 180 as (x >> 2) / 45, with 45 done by a reciprocal multiply
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W = 19;
    localparam logic [RECIP_W-1:0] RECIP_45 = RECIP_W'((2**RECIP_SHIFT + 44) / 45);

    // command codes
    typedef enum logic [1:0] {
        CMD_SET_POS = 2'd0,
        CMD_HOME    = 2'd1,
        CMD_TICK    = 2'd2
    } t_cmd;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_ANGLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 3'd6;

    // reset values
    localparam logic [ANGLE_W-1:0] RST_MIN_ANGLE   = 8'd0;
    localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE   = 8'd180;
    localparam logic [ANGLE_W-1:0] RST_HOME_ANGLE  = 8'd90;
    localparam logic [ANGLE_W-1:0] RST_START_ANGLE = 8'd90;
    localparam logic [PULSE_W-1:0] RST_MIN_PULSE   = 12'd150;
    localparam logic [PULSE_W-1:0] RST_MAX_PULSE   = 12'd600;
    localparam logic [ANGLE_W-1:0] RST_STEP_SIZE   = 8'd5;

    // results that travel down the pulse pipeline with the angle
    typedef struct packed {
        logic                 pwm_write;
        logic [ANGLE_W-1:0]   cmd_angle;
        logic [ANGLE_W-1:0]   act_angle;
    } t_angles;

endpackage

@@ hw/rtl/servo_slew_limiter.sv @@
// servo slew limiter top level: angle state, slew step and pulse mapping pipeline
//
//  channel | valid   | stall    | payload
//  --------+---------+----------+----------------------------------------------
//  input   | i_valid | o_stall  | i_cmd, i_target_angle, i_drive_enabled
//  output  | o_valid | i_stall  | o_pwm_write, o_pulse_length, o_commanded_angle,
//          |         |          | o_actual_angle, o_at_position
//  config  | i_cfg_we| -        | i_cfg_idx, i_cfg_data
//
// one word accepted per cycle while o_stall is low; its result word passes the s1, s2, s3 and out registers
// the pipeline follows the pulse map: angle update, span multiply, reciprocal
//   divide by 180, then offset add and saturate, one register stage each
// angle state updates in the accept cycle, so back-to-back ticks see each other
// synchronous active-low reset loads the register reset values, no clearing pass
// a stall on the output holds the pipeline; o_stall rises only when all four stages
//   are full and the output is stalled
module servo_slew_limiter
    import ssl_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,

    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_cmd,
    input  logic signed [TARGET_W-1:0] i_target_angle,
    input  logic                       i_drive_enabled,

    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_pwm_write,
    output logic [PULSE_W-1:0]         o_pulse_length,
    output logic [ANGLE_W-1:0]         o_commanded_angle,
    output logic [ANGLE_W-1:0]         o_actual_angle,
    output logic                       o_at_position
);

    // configuration registers
    logic [ANGLE_W-1:0] r_min_angle, r_max_angle, r_home_angle;
    logic [PULSE_W-1:0] r_min_pulse, r_max_pulse;
    logic [ANGLE_W-1:0] r_step_size;

    // angle state
    logic [ANGLE_W-1:0] r_cmd_pos, r_act_pos;
    logic [ANGLE_W-1:0] n_cmd_pos, n_act_pos;
    logic               n_write;

    // pipeline registers
    logic                      r_s1_v, r_s2_v, r_s3_v, r_out_v;
    t_angles                   r_s1, r_s2, r_s3;
    logic signed [21:0]        r_s2_prod;
    logic [12:0]               r_s3_quot;
    logic                      r_s3_neg;
    logic                      r_out_write;
    logic [PULSE_W-1:0]        r_out_pulse;
    logic [ANGLE_W-1:0]        r_out_cmd, r_out_act;

    // flow control: a stage moves when the one after it has room
    logic out_ready, s3_adv, s2_adv, s1_adv, in_acc;

    assign out_ready = !r_out_v || !i_stall;
    assign s3_adv    = !r_s3_v || out_ready;
    assign s2_adv    = !r_s2_v || s3_adv;
    assign s1_adv    = !r_s1_v || s2_adv;
    assign o_stall   = !s1_adv;
    assign in_acc    = i_valid && s1_adv;

    // ---------------- configuration writes ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_angle   <= RST_MIN_ANGLE;
            r_max_angle   <= RST_MAX_ANGLE;
            r_home_angle  <= RST_HOME_ANGLE;
            r_min_pulse   <= RST_MIN_PULSE;
            r_max_pulse   <= RST_MAX_PULSE;
            r_step_size   <= RST_STEP_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_ANGLE:   r_min_angle   <= i_cfg_data[ANGLE_W-1:0];
                REG_MAX_ANGLE:   r_max_angle   <= i_cfg_data[ANGLE_W-1:0];
                REG_HOME_ANGLE:  r_home_angle  <= i_cfg_data[ANGLE_W-1:0];
                REG_START_ANGLE: ; // only reloads both angles, in the state block
                REG_MIN_PULSE:   r_min_pulse   <= i_cfg_data[PULSE_W-1:0];
                REG_MAX_PULSE:   r_max_pulse   <= i_cfg_data[PULSE_W-1:0];
                REG_STEP_SIZE:   r_step_size   <= i_cfg_data[ANGLE_W-1:0];
                default: ; // unknown index, write dropped
            endcase
        end
    end

    // ---------------- angle update (accept cycle) ----------------
    logic signed [TARGET_W-1:0] min_s, max_s;
    logic [ANGLE_W-1:0]         tgt_clamped;
    logic [ANGLE_W-1:0]         diff, inc, stepped, step_clamped;
    logic                       moving_up;

    assign min_s = $signed({{(TARGET_W-ANGLE_W){1'b0}}, r_min_angle});
    assign max_s = $signed({{(TARGET_W-ANGLE_W){1'b0}}, r_max_angle});

    // clamp of the signed target: low limit checked first (matters when limits cross)
    always_comb begin
        if (i_target_angle < min_s) begin
            tgt_clamped = r_min_angle;
        end else if (i_target_angle > max_s) begin
            tgt_clamped = r_max_angle;
        end else begin
            tgt_clamped = i_target_angle[ANGLE_W-1:0];
        end
    end

    // one slew step toward the commanded angle, no overshoot
    assign moving_up = r_act_pos < r_cmd_pos;
    assign diff      = moving_up ? (r_cmd_pos - r_act_pos) : (r_act_pos - r_cmd_pos);
    assign inc       = (diff <= r_step_size) ? diff : r_step_size;
    assign stepped   = moving_up ? (r_act_pos + inc) : (r_act_pos - inc);

    always_comb begin
        if (stepped < r_min_angle) begin
            step_clamped = r_min_angle;
        end else if (stepped > r_max_angle) begin
            step_clamped = r_max_angle;
        end else begin
            step_clamped = stepped;
        end
    end

    always_comb begin
        n_cmd_pos = r_cmd_pos;
        n_act_pos = r_act_pos;
        n_write   = 1'b0;
        case (t_cmd'(i_cmd))
            CMD_SET_POS: begin
                n_cmd_pos = tgt_clamped;
            end
            CMD_HOME: begin
                if (i_drive_enabled) begin
                    // home angle taken unclamped
                    n_cmd_pos = r_home_angle;
                    n_act_pos = r_home_angle;
                    n_write   = 1'b1;
                end
            end
            CMD_TICK: begin
                if (i_drive_enabled && (r_act_pos != r_cmd_pos)) begin
                    n_act_pos = step_clamped;
                    n_write   = 1'b1;
                end
            end
            default: ; // unused command, nothing changes
        endcase
    end

    // state registers; a start angle write reloads both angles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_pos <= RST_START_ANGLE;
            r_act_pos <= RST_START_ANGLE;
        end else if (i_cfg_we && (i_cfg_idx == REG_START_ANGLE)) begin
            r_cmd_pos <= i_cfg_data[ANGLE_W-1:0];
            r_act_pos <= i_cfg_data[ANGLE_W-1:0];
        end else if (in_acc) begin
            r_cmd_pos <= n_cmd_pos;
            r_act_pos <= n_act_pos;
        end
    end

    // ---------------- pulse map pipeline ----------------
    // stage 2 multiplies angle by signed span
    logic signed [PULSE_W:0] span;
    logic signed [21:0]      prod;

    assign span = $signed({1'b0, r_max_pulse}) - $signed({1'b0, r_min_pulse});
    assign prod = 22'($signed({1'b0, r_s1.act_angle}) * span);

    // stage 3 divides the magnitude by 180: (|p| >> 2) * ceil(2^24/45) >> 24
    logic [21:0] prod_mag;
    logic [17:0] quarter;
    logic [36:0] recip_prod;

    assign prod_mag   = r_s2_prod[21] ? 22'(-r_s2_prod) : r_s2_prod;
    assign quarter    = prod_mag[19:2];
    assign recip_prod = 37'(quarter * RECIP_45);

    // output stage: offset, sign (truncation toward zero) and saturate
    logic signed [14:0] pulse_sum;
    logic [PULSE_W-1:0] pulse_sat;

    assign pulse_sum = r_s3_neg
        ? ($signed({3'b000, r_min_pulse}) - $signed({2'b00, r_s3_quot}))
        : ($signed({3'b000, r_min_pulse}) + $signed({2'b00, r_s3_quot}));

    always_comb begin
        if (pulse_sum < 0) begin
            pulse_sat = '0;
        end else if (pulse_sum > 15'(PULSE_MAX)) begin
            pulse_sat = PULSE_W'(PULSE_MAX);
        end else begin
            pulse_sat = pulse_sum[PULSE_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s1_adv)    r_s1_v  <= i_valid;
            if (s2_adv)    r_s2_v  <= r_s1_v;
            if (s3_adv)    r_s3_v  <= r_s2_v;
            if (out_ready) r_out_v <= r_s3_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1.pwm_write <= n_write;
            r_s1.cmd_angle <= n_cmd_pos;
            r_s1.act_angle <= n_act_pos;
        end
        if (s2_adv) begin
            r_s2      <= r_s1;
            r_s2_prod <= prod;
        end
        if (s3_adv) begin
            r_s3      <= r_s2;
            r_s3_quot <= recip_prod[36:24];
            r_s3_neg  <= r_s2_prod[21];
        end
        if (out_ready) begin
            r_out_write <= r_s3.pwm_write;
            r_out_pulse <= r_s3.pwm_write ? pulse_sat : '0;
            r_out_cmd   <= r_s3.cmd_angle;
            r_out_act   <= r_s3.act_angle;
        end
    end

    assign o_valid           = r_out_v;
    assign o_pwm_write       = r_out_write;
    assign o_pulse_length    = r_out_pulse;
    assign o_commanded_angle = r_out_cmd;
    assign o_actual_angle    = r_out_act;
    assign o_at_position     = (r_out_cmd == r_out_act);

    // ---------------- assertions ----------------
    a_no_write_zero_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pwm_write) |-> (o_pulse_length == '0))
        else $error("pulse length nonzero without a pulse write");

    a_disabled_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_cmd == CMD_TICK) && !i_drive_enabled && !i_cfg_we)
        |=> (r_act_pos == $past(r_act_pos)))
        else $error("actual angle moved on a disabled tick");

    a_set_keeps_actual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_cmd == CMD_SET_POS) && !i_cfg_we)
        |=> (r_act_pos == $past(r_act_pos)))
        else $error("set position changed the actual angle");

    a_tick_writes_new_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_write) |=> (r_s1.act_angle == r_act_pos))
        else $error("pulse pipeline angle differs from stored actual angle");

endmodule
